/* hdl/dns_name_decompress_macros.svh */
// ---------------------------------------------------------------------------
// DNS name decompressor assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESS_MACROS_SVH
`define DNS_NAME_DECOMPRESS_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DND_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define DND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`define DND_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`else

`define DND_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define DND_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`define DND_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

/* hdl/dnd_pkg.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor package
// Shared constants, codes and the walker-to-packer control structs.
// ---------------------------------------------------------------------------
package dnd_pkg;

	// position width: holds a 14-bit pointer target and any buffer offset
	localparam int POS_W = 14;

	localparam int PACKET_BYTES_DEF   = 512;
	localparam int MAX_NAME_BYTES_DEF = 255;

	localparam logic [5:0] HOPS_RESET = 6'd16;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_HOPS  = 2'd1;
	localparam logic [1:0] STATUS_LONG  = 2'd2;
	localparam logic [1:0] STATUS_RANGE = 2'd3;

	localparam logic [7:0] POINTER_MARK = 8'd192;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;

	localparam logic [2:0] COUNT_FULL = 3'd4;

	typedef struct packed {
		logic       push;
		logic [7:0] ch;
		logic       flush;
		logic [1:0] status;
	} pack_req_t;

	typedef struct packed {
		logic push_ok;
		logic flush_ok;
	} pack_rdy_t;

endpackage

/* hdl/dns_name_decompress.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor
// Loads packet bytes into a buffer and expands compressed names into
// dotted text, up to four characters per output beat.
// ---------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       input      in_valid / in_stall        command byte_addr byte_value start_offset
// out      output     out_valid / out_stall      char0..char3 char_count last status
// cfg      input      cfg_write                  cfg_data (max_pointer_hops)
//
// A load writes one byte while the walker is idle. A decode starts, then steps
// through each terminator or label length byte, both bytes of each pointer,
// each label character and each label end, and emits the last beat; the single
// read port of the packet buffer sets this pace, one byte per cycle unless the output stalls.
// Reset clears the sequencer, the packer and sets max_pointer_hops to 16;
// the buffer is not cleared. A stalled output holds the walk when a full
// beat or the last beat is ready.
// ---------------------------------------------------------------------------
module dns_name_decompress #(
	parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
	parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [8:0] byte_addr,
	input  logic [7:0] byte_value,
	input  logic [8:0] start_offset,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char0,
	output logic [7:0] char1,
	output logic [7:0] char2,
	output logic [7:0] char3,
	output logic [2:0] char_count,
	output logic       last,
	output logic [1:0] status,
	input  logic       cfg_write,
	input  logic [5:0] cfg_data
);
	import dnd_pkg::*;

	logic [5:0]       max_hops_q;
	logic             wr_en;
	logic [POS_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic [POS_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	pack_req_t        req;
	pack_rdy_t        rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hops_q <= HOPS_RESET;
		end else if (cfg_write) begin
			max_hops_q <= cfg_data;
		end
	end

	dnd_store #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dnd_walker #(
		.PACKET_BYTES  (PACKET_BYTES),
		.MAX_NAME_BYTES(MAX_NAME_BYTES)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.byte_addr   (byte_addr),
		.byte_value  (byte_value),
		.start_offset(start_offset),
		.max_hops    (max_hops_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.req         (req),
		.rdy         (rdy)
	);

	dnd_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rdy       (rdy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char0     (char0),
		.char1     (char1),
		.char2     (char2),
		.char3     (char3),
		.char_count(char_count),
		.last      (last),
		.status    (status)
	);

endmodule

/* hdl/dnd_store.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor packet store
// Single-port-write, registered-read byte memory holding the packet.
// ---------------------------------------------------------------------------
module dnd_store #(
	parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [dnd_pkg::POS_W-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic [dnd_pkg::POS_W-1:0] rd_addr,
	output logic [7:0]               rd_data
);
	import dnd_pkg::*;

	localparam int ADDR_W = $clog2(PACKET_BYTES);

	logic [7:0] mem_q [PACKET_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[ADDR_W-1:0]] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr[ADDR_W-1:0]];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/dnd_packer.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor character packer
// Collects name characters four to a beat and holds the output register.
// ---------------------------------------------------------------------------
`include "dns_name_decompress_macros.svh"

module dnd_packer (
	input  logic               clk,
	input  logic               arst_n,
	input  dnd_pkg::pack_req_t req,
	output dnd_pkg::pack_rdy_t rdy,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char0,
	output logic [7:0]         char1,
	output logic [7:0]         char2,
	output logic [7:0]         char3,
	output logic [2:0]         char_count,
	output logic               last,
	output logic [1:0]         status
);
	import dnd_pkg::*;

	logic [3:0][7:0] pack_q;
	logic [1:0]      fill_q;
	logic            out_valid_q;
	logic [3:0][7:0] out_char_q;
	logic [2:0]      out_count_q;
	logic            out_last_q;
	logic [1:0]      out_status_q;
	logic            out_free;
	logic            push_fire;
	logic            flush_fire;

	assign out_free     = !out_valid_q || !out_stall;
	assign rdy.push_ok  = (fill_q != 2'd3) || out_free;
	assign rdy.flush_ok = out_free;
	assign push_fire    = req.push && rdy.push_ok;
	assign flush_fire   = req.flush && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fill_q      <= 2'd0;
			pack_q      <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (push_fire) begin
				if (fill_q == 2'd3) begin
					out_valid_q <= 1'b1;
					pack_q      <= '0;
					fill_q      <= 2'd0;
				end else begin
					pack_q[fill_q] <= req.ch;
					fill_q         <= fill_q + 2'd1;
				end
			end else if (flush_fire) begin
				out_valid_q <= 1'b1;
				pack_q      <= '0;
				fill_q      <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire && fill_q == 2'd3) begin
			out_char_q   <= {req.ch, pack_q[2], pack_q[1], pack_q[0]};
			out_count_q  <= COUNT_FULL;
			out_last_q   <= 1'b0;
			out_status_q <= STATUS_OK;
		end else if (flush_fire) begin
			out_char_q   <= pack_q;
			out_count_q  <= {1'b0, fill_q};
			out_last_q   <= 1'b1;
			out_status_q <= req.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign char0      = out_char_q[0];
	assign char1      = out_char_q[1];
	assign char2      = out_char_q[2];
	assign char3      = out_char_q[3];
	assign char_count = out_count_q;
	assign last       = out_last_q;
	assign status     = out_status_q;

	`DND_ASSERT_IMPLY(a_mid_beat_full, clk, arst_n, out_valid_q && !out_last_q, out_count_q == COUNT_FULL)
	`DND_ASSERT_NEXT(a_group_emits, clk, arst_n, push_fire && fill_q == 2'd3, out_valid_q && out_count_q == COUNT_FULL)
	`DND_ASSERT_NEXT(a_flush_emits, clk, arst_n, flush_fire, out_valid_q && out_last_q && fill_q == 2'd0)

endmodule

/* hdl/dnd_walker.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor label walker
// Sequencer that steps through labels and pointers one byte per cycle unless the packer stalls it.
// ---------------------------------------------------------------------------
`include "dns_name_decompress_macros.svh"

module dnd_walker #(
	parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
	parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [8:0]                byte_addr,
	input  logic [7:0]                byte_value,
	input  logic [8:0]                start_offset,
	input  logic [5:0]                max_hops,
	output logic                      wr_en,
	output logic [dnd_pkg::POS_W-1:0] wr_addr,
	output logic [7:0]                wr_data,
	output logic [dnd_pkg::POS_W-1:0] rd_addr,
	input  logic [7:0]                rd_data,
	output dnd_pkg::pack_req_t        req,
	input  dnd_pkg::pack_rdy_t        rdy
);
	import dnd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HEAD = 3'd1;
	localparam logic [2:0] ST_PTR  = 3'd2;
	localparam logic [2:0] ST_LBL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [POS_W-1:0] POS_END  = POS_W'(PACKET_BYTES);
	localparam logic [9:0]       NAME_MAX = 10'(MAX_NAME_BYTES);

	logic [2:0]       state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [5:0]       hops_q, hops_d;
	logic [7:0]       enc_q, enc_d;
	logic [7:0]       rem_q, rem_d;
	logic             first_q, first_d;
	logic [5:0]       hi_q, hi_d;
	logic [1:0]       status_q, status_d;
	logic             accept;
	logic [POS_W-1:0] pos_next;
	logic [9:0]       len_sum;
	logic             enc_ok;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign wr_en    = accept && (command == CMD_LOAD) && (POS_W'(byte_addr) < POS_END);
	assign wr_addr  = POS_W'(byte_addr);
	assign wr_data  = byte_value;
	assign rd_addr  = pos_d;
	assign pos_next = pos_q + POS_W'(1);
	assign len_sum  = {2'b00, enc_q} + {2'b00, rd_data} + 10'd2;
	assign enc_ok   = ({2'b00, enc_q} < NAME_MAX);

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		hops_d     = hops_q;
		enc_d      = enc_q;
		rem_d      = rem_q;
		first_d    = first_q;
		hi_d       = hi_q;
		status_d   = status_q;
		req        = '0;
		req.ch     = DOT_CHAR;
		req.status = status_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_DECODE) begin
					pos_d    = POS_W'(start_offset);
					hops_d   = 6'd0;
					enc_d    = 8'd0;
					rem_d    = 8'd0;
					first_d  = 1'b1;
					status_d = STATUS_OK;
					if (POS_W'(start_offset) >= POS_END) begin
						status_d = STATUS_RANGE;
						state_d  = ST_DONE;
					end else begin
						state_d = ST_HEAD;
					end
				end
			end
			ST_HEAD: begin
				if (rd_data == 8'd0) begin
					status_d = STATUS_OK;
					state_d  = ST_DONE;
				end else if (rd_data >= POINTER_MARK) begin
					if (pos_next >= POS_END) begin
						status_d = STATUS_RANGE;
						state_d  = ST_DONE;
					end else if (hops_q >= max_hops) begin
						status_d = STATUS_HOPS;
						state_d  = ST_DONE;
					end else begin
						hi_d    = rd_data[5:0];
						pos_d   = pos_next;
						state_d = ST_PTR;
					end
				end else if (len_sum > NAME_MAX) begin
					status_d = STATUS_LONG;
					state_d  = ST_DONE;
				end else begin
					req.push = !first_q;
					if (first_q || rdy.push_ok) begin
						first_d = 1'b0;
						enc_d   = enc_q + rd_data + 8'd1;
						pos_d   = pos_next;
						rem_d   = rd_data;
						state_d = ST_LBL;
					end
				end
			end
			ST_PTR: begin
				hops_d = hops_q + 6'd1;
				if ({hi_q, rd_data} >= POS_END) begin
					status_d = STATUS_RANGE;
					state_d  = ST_DONE;
				end else begin
					pos_d   = {hi_q, rd_data};
					state_d = ST_HEAD;
				end
			end
			ST_LBL: begin
				if (pos_q >= POS_END) begin
					status_d = STATUS_RANGE;
					state_d  = ST_DONE;
				end else if (rem_q == 8'd0) begin
					state_d = ST_HEAD;
				end else begin
					req.push = 1'b1;
					req.ch   = rd_data;
					if (rdy.push_ok) begin
						pos_d = pos_next;
						rem_d = rem_q - 8'd1;
					end
				end
			end
			ST_DONE: begin
				req.flush = 1'b1;
				if (rdy.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			hops_q   <= 6'd0;
			enc_q    <= 8'd0;
			rem_q    <= 8'd0;
			first_q  <= 1'b1;
			hi_q     <= 6'd0;
			status_q <= STATUS_OK;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			hops_q   <= hops_d;
			enc_q    <= enc_d;
			rem_q    <= rem_d;
			first_q  <= first_d;
			hi_q     <= hi_d;
			status_q <= status_d;
		end
	end

	`DND_ASSERT_NEXT(a_flush_to_idle, clk, arst_n, req.flush && rdy.flush_ok, state_q == ST_IDLE)
	`DND_ASSERT_IMPLY(a_hops_bounded, clk, arst_n, state_q != ST_IDLE, hops_q <= max_hops)
	`DND_ASSERT_ALWAYS(a_name_bounded, clk, arst_n, enc_ok)

endmodule

/* tb/tb_dns_name_decompress.sv */
// ---------------------------------------------------------------------------
// DNS name decompressor testbench
// Loads packet bytes, builds label chains with and without compression
// pointers, decodes them under several hop limits and checks every output
// beat against a behavioral predictor kept in a small scoreboard class.
// ---------------------------------------------------------------------------

typedef struct packed {
	logic       command;
	logic [8:0] addr;
	logic [7:0] value;
	logic [8:0] start;
} dns_cmd_t;

typedef struct packed {
	logic [3:0][7:0] ch;
	logic [2:0]      count;
	logic            last;
	logic [1:0]      status;
} name_beat_t;

class name_scoreboard;
	localparam int PKT_BYTES = dnd_pkg::PACKET_BYTES_DEF;
	localparam int NAME_LIMIT = dnd_pkg::MAX_NAME_BYTES_DEF;

	bit [7:0]        packet_mem[PKT_BYTES];
	bit              loaded[PKT_BYTES];
	bit [5:0]        hop_limit;
	name_beat_t      walk_beats[$];
	name_beat_t      pending[$];
	bit [3:0][7:0]   pack;
	int              fill;
	int              errors;

	function new();
		hop_limit = dnd_pkg::HOPS_RESET;
		errors = 0;
		foreach (loaded[i]) loaded[i] = 1'b0;
	endfunction

	function void push_char(bit [7:0] c);
		pack[fill] = c;
		fill++;
		if (fill == 4) begin
			walk_beats.push_back('{ch: pack, count: dnd_pkg::COUNT_FULL, last: 1'b0,
				status: dnd_pkg::STATUS_OK});
			pack = '0;
			fill = 0;
		end
	endfunction

	// Walk the name at start_pos into walk_beats. Returns the first address
	// that would be read before being loaded, or -1 when the walk is complete.
	function int decode_name(bit [8:0] start_pos);
		int       pos;
		int       hops;
		int       enc_len;
		int       len;
		bit       first_lbl;
		bit [1:0] st;
		bit [7:0] b;
		walk_beats.delete();
		pos = start_pos;
		hops = 0;
		enc_len = 0;
		pack = '0;
		fill = 0;
		first_lbl = 1'b1;
		st = dnd_pkg::STATUS_OK;
		forever begin
			if (pos >= PKT_BYTES) begin
				st = dnd_pkg::STATUS_RANGE;
				break;
			end
			if (!loaded[pos])
				return pos;
			b = packet_mem[pos];
			if (b == 8'd0)
				break;
			if (b >= dnd_pkg::POINTER_MARK) begin
				if (pos + 1 >= PKT_BYTES) begin
					st = dnd_pkg::STATUS_RANGE;
					break;
				end
				if (!loaded[pos + 1])
					return pos + 1;
				if (hops >= hop_limit) begin
					st = dnd_pkg::STATUS_HOPS;
					break;
				end
				hops++;
				pos = {b[5:0], packet_mem[pos + 1]};
				continue;
			end
			if (enc_len + b + 2 > NAME_LIMIT) begin
				st = dnd_pkg::STATUS_LONG;
				break;
			end
			if (!first_lbl)
				push_char(dnd_pkg::DOT_CHAR);
			first_lbl = 1'b0;
			enc_len += 1 + b;
			pos++;
			len = b;
			while (len != 0) begin
				if (pos >= PKT_BYTES) begin
					st = dnd_pkg::STATUS_RANGE;
					break;
				end
				if (!loaded[pos])
					return pos;
				push_char(packet_mem[pos]);
				pos++;
				len--;
			end
			if (st != dnd_pkg::STATUS_OK)
				break;
		end
		walk_beats.push_back('{ch: pack, count: 3'(fill), last: 1'b1, status: st});
		return -1;
	endfunction

	function void note_input(dns_cmd_t item);
		if (item.command == dnd_pkg::CMD_LOAD) begin
			packet_mem[item.addr] = item.value;
			loaded[item.addr] = 1'b1;
		end else begin
			void'(decode_name(item.start));
			foreach (walk_beats[i]) pending.push_back(walk_beats[i]);
		end
	endfunction

	function void check_field(string fname, int want, int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", fname, want, got);
			errors++;
		end
	endfunction

	function void check_result(name_beat_t got);
		name_beat_t want;
		if (pending.size() == 0) begin
			$error("unexpected beat: count %0d last %0d status %0d",
				got.count, got.last, got.status);
			errors++;
			return;
		end
		want = pending.pop_front();
		for (int i = 0; i < 4; i++)
			check_field($sformatf("char%0d", i), want.ch[i], got.ch[i]);
		check_field("char_count", want.count, got.count);
		check_field("last", want.last, got.last);
		check_field("status", want.status, got.status);
	endfunction

	function void report_leftover();
		if (pending.size() != 0) begin
			$error("%0d expected beats never arrived", pending.size());
			errors++;
		end
	endfunction
endclass

module tb_dns_name_decompress;
	import dnd_pkg::*;

	localparam int PKT = PACKET_BYTES_DEF;
	localparam int ITEM_TARGET = 330;
	localparam int SETTLE_CYCLES = 24;
	localparam int RUN_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = CMD_LOAD;
	logic [8:0] byte_addr = '0;
	logic [7:0] byte_value = '0;
	logic [8:0] start_offset = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] char0;
	logic [7:0] char1;
	logic [7:0] char2;
	logic [7:0] char3;
	logic [2:0] char_count;
	logic       last;
	logic [1:0] status;
	logic       cfg_write = 1'b0;
	logic [5:0] cfg_data = HOPS_RESET;

	name_scoreboard sb;
	name_scoreboard gen_mirror;
	int             items_sent = 0;
	int             free_pos = 16;
	int             name_heads[$];
	int             cycle_count = 0;
	int             hold_left = 0;
	bit             hold_done = 1'b0;

	dns_name_decompress u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.byte_addr(byte_addr),
		.byte_value(byte_value),
		.start_offset(start_offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char0(char0),
		.char1(char1),
		.char2(char2),
		.char3(char3),
		.char_count(char_count),
		.last(last),
		.status(status),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input({command, byte_addr, byte_value, start_offset});
		if (arst_n && out_valid && !out_stall)
			sb.check_result({{char3, char2, char1, char0}, char_count, last, status});
	end

	// hold off once for a long stretch, stay quiet through a middle window
	always @(posedge clk) begin
		if (!hold_done && items_sent >= 120) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (items_sent >= 200 && items_sent < 260) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 23);
		end
	end

	task automatic send_beat(logic cmd, logic [8:0] a, logic [7:0] v, logic [8:0] s);
		if (!(items_sent >= 200 && items_sent < 260) && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		if (cmd == CMD_LOAD)
			gen_mirror.note_input({cmd, a, v, s});
		in_valid <= 1'b1;
		command <= cmd;
		byte_addr <= a;
		byte_value <= v;
		start_offset <= s;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic load_byte(int addr, int value);
		send_beat(CMD_LOAD, 9'(addr), 8'(value), 9'($urandom_range(511)));
	endtask

	function automatic int fill_byte();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(5, 1);
		return $urandom_range(255);
	endfunction

	function automatic int name_char();
		if ($urandom_range(4) != 0)
			return $urandom_range(8'h7A, 8'h61);
		return $urandom_range(255);
	endfunction

	// load any byte the walk would read unwritten, then decode
	task automatic decode_at(int start);
		int miss;
		miss = gen_mirror.decode_name(9'(start));
		while (miss >= 0) begin
			load_byte(miss, fill_byte());
			miss = gen_mirror.decode_name(9'(start));
		end
		send_beat(CMD_DECODE, 9'($urandom_range(511)), 8'($urandom_range(255)), 9'(start));
	endtask

	function automatic int claim(int need);
		if (free_pos + need > PKT)
			free_pos = $urandom_range(80, 16);
		return free_pos;
	endfunction

	task automatic write_pointer(int at, int tgt);
		load_byte(at, POINTER_MARK | 8'(tgt >> 8));
		load_byte(at + 1, tgt & 255);
	endtask

	task automatic build_name();
		int head;
		int p;
		int nlab;
		int len;
		head = claim(68);
		p = head;
		nlab = $urandom_range(3, 0);
		repeat (nlab) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
			load_byte(p, len);
			p++;
			repeat (len) begin
				load_byte(p, name_char());
				p++;
			end
		end
		if (name_heads.size() != 0 && $urandom_range(1)) begin
			write_pointer(p, name_heads[$urandom_range(name_heads.size() - 1)]);
			p += 2;
		end else begin
			load_byte(p, 0);
			p++;
		end
		name_heads.push_back(head);
		free_pos = p;
		decode_at(head);
	endtask

	task automatic build_long();
		int head;
		int len;
		int tgt;
		len = $urandom_range(1) ? 63 : $urandom_range(191, 64);
		head = claim(len + 4);
		load_byte(head, len);
		for (int i = 1; i <= len; i++)
			load_byte(head + i, name_char());
		if ($urandom_range(1) || name_heads.size() == 0)
			tgt = head;
		else
			tgt = name_heads[$urandom_range(name_heads.size() - 1)];
		write_pointer(head + len + 1, tgt);
		free_pos = head + len + 3;
		decode_at(head);
	endtask

	task automatic build_pointer();
		int p;
		int tgt;
		p = claim(3);
		if (name_heads.size() != 0 && $urandom_range(1))
			tgt = name_heads[$urandom_range(name_heads.size() - 1)];
		else
			tgt = $urandom_range(16383);
		write_pointer(p, tgt);
		free_pos = p + 2;
		decode_at(p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hops(logic [5:0] v);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.hop_limit = v;
		gen_mirror.hop_limit = v;
	endtask

	initial begin
		int       goal;
		int       r;
		logic [5:0] phase_hops[4];
		sb = new();
		gen_mirror = new();
		phase_hops[0] = 6'd1;
		phase_hops[1] = 6'd63;
		phase_hops[2] = 6'($urandom_range(62, 2));
		phase_hops[3] = HOPS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root name
		load_byte(0, 0);
		decode_at(0);
		// two labels, raw high byte inside a label
		load_byte(1, 2);
		load_byte(2, 8'h61);
		load_byte(3, 8'h62);
		load_byte(4, 1);
		load_byte(5, 8'hFF);
		load_byte(6, 0);
		decode_at(1);
		// pointer to that name
		write_pointer(7, 1);
		decode_at(7);
		// pointer to itself: hop limit
		write_pointer(9, 9);
		decode_at(9);
		// pointer target beyond the buffer
		load_byte(509, 8'hFF);
		load_byte(510, 8'hFF);
		decode_at(509);
		// pointer in the last byte
		load_byte(511, 8'hC0);
		decode_at(511);
		// label running off the end of the buffer
		load_byte(508, 4);
		decode_at(508);
		free_pos = 16;

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			write_hops(phase_hops[phase]);
			goal = (ITEM_TARGET * (phase + 1)) / 4;
			if (phase < 2)
				build_long();
			while (items_sent < goal) begin
				r = $urandom_range(99);
				if (r < 35 && name_heads.size() != 0)
					decode_at(name_heads[$urandom_range(name_heads.size() - 1)]);
				else if (r < 65)
					build_name();
				else if (r < 75)
					decode_at($urandom_range(511));
				else if (r < 85)
					load_byte($urandom_range(511), $urandom_range(255));
				else if (r < 96)
					build_pointer();
				else
					build_long();
			end
		end

		drain();
		sb.report_leftover();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
